@@ rtl/core/rcast_pkg.sv @@
// Shared types and constants for the occupancy grid ray caster.
// No dependencies; rcast_div and the top level import this package.
`default_nettype none

package rcast_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_CELL_SIZE  = 3'd2,
    CFG_RAY_COUNT  = 3'd3,
    CFG_MIN_ANGLE  = 3'd4,
    CFG_MAX_ANGLE  = 3'd5,
    CFG_MAX_RANGE  = 3'd6,
    CFG_RANGE_STEP = 3'd7
  } cfg_reg_e;

  // Command and status codes
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_SCAN     = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD_CFG = 1'b1;

  // Angles
  localparam logic [15:0] ANG_QUARTER = 16'd16384;
  localparam logic [16:0] ANG_HALF    = 17'd32768;

  // Shared divider
  localparam int unsigned DIV_W = 50;   // remainder / shifted divisor
  localparam int unsigned DEN_W = 34;
  localparam int unsigned QUO_W = 25;
  localparam int unsigned NB_W  = 5;

  localparam logic [NB_W-1:0] NB_LIMIT = 5'd25;
  localparam logic [NB_W-1:0] NB_ANGLE = 5'd16;
  localparam logic [NB_W-1:0] NB_CELL  = 5'd7;

  // 5 * 2^30, denominator constant of the half-sine approximation
  localparam logic [DEN_W-1:0] SIN_DEN_K = 34'd5368709120;

  // Trig increment width (Q15 trig times Q8.8 step)
  localparam int unsigned INC_W = 34;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [NB_W-1:0]  nbits;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RNG,
    ST_XL,
    ST_YL,
    ST_LIM,
    ST_LIMW,
    ST_RAY,
    ST_OFF,
    ST_OFFW,
    ST_ANG,
    ST_TRM,
    ST_TRD,
    ST_TRW,
    ST_INCX,
    ST_INCY,
    ST_INIT,
    ST_STEP,
    ST_CHK,
    ST_COLW,
    ST_ROW,
    ST_ROWW,
    ST_IDX,
    ST_RD,
    ST_HIT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/rcast_if.sv @@
// Valid/ready channel interfaces for the ray caster: request and result beats.
// No dependencies.
`default_nettype none

interface rcast_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [11:0] cell_index;
  logic               cell_occupied;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic        [15:0] pose_heading;

  modport source (output valid, command, cell_index, cell_occupied, pose_x, pose_y,
                  pose_heading, input ready);
  modport sink   (input valid, command, cell_index, cell_occupied, pose_x, pose_y,
                  pose_heading, output ready);
endinterface

interface rcast_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  ray_index;
  logic [23:0] range_value;
  logic        status;
  logic        last;

  modport source (output valid, ray_index, range_value, status, last, input ready);
  modport sink   (input valid, ray_index, range_value, status, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rcast_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on rcast_pkg (div_req_t, widths).
`default_nettype none

module rcast_div
  import rcast_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [NB_W-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  always_comb begin
    ge     = rem_q >= dsh_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsh_d  = DIV_W'(req_i.den) << (req_i.nbits - NB_W'(1));
      quo_d  = '0;
      cnt_d  = req_i.nbits;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - NB_W'(1);
      if (cnt_q == NB_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/rcast_grid.sv @@
// Occupancy bit memory: one write port, one registered read port,
// clearing pass after reset. No dependencies.
`default_nettype none

module rcast_grid #(
  parameter  int unsigned GRID_CELLS = 4096,
  localparam int unsigned AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o,
  output logic          busy_o
);

  logic          mem_q [GRID_CELLS];
  logic          rdata_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          busy_q, busy_d;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (clr_q == AW'(GRID_CELLS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= 1'b0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

@@ rtl/core/occupancy_grid_lidar_raycast.sv @@
// Occupancy grid lidar ray caster: top level with sequencer, shared multiplier and grid.
// Depends on rcast_pkg, rcast_if, rcast_div and rcast_grid.
`default_nettype none

// A cell write beat with an index inside the grid is stored. A scan beat answers with one
// result beat per ray (or a single error beat for a bad configuration) and the block takes
// no request until the last result has been taken. The work runs on one multiplier and one
// restoring divider (one quotient bit per cycle) under a sequencer, so the divider sets the
// pace: scan setup does one division (the step limit); each ray divides for its offset
// (only with more than one ray) and for two sines, then each march step divides for the
// column and the row and then does one grid read. After reset the grid is cleared one cell
// per cycle; configuration writes are taken meanwhile, requests are not.
module occupancy_grid_lidar_raycast
  import rcast_pkg::*;
#(
  parameter int unsigned GRID_CELLS = 4096,
  parameter int unsigned MAX_RAYS   = 64,
  parameter int unsigned MAX_STEPS  = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcast_in_if.sink              in_i,
  rcast_out_if.source           out_o
);

  localparam int unsigned AW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int unsigned LW    = $clog2(MAX_STEPS + 1);   // step counter / limit
  localparam int unsigned DW    = 16 + LW;                 // marched distance
  localparam int unsigned ACC_W = INC_W + LW;              // trig * distance
  localparam int unsigned XW    = ACC_W - 14;              // point coordinate

  // ---------------------------------------------------------------- config regs
  logic        [6:0]  map_w_q, map_h_q, ray_cnt_q;
  logic        [15:0] cell_sz_q, min_ang_q, max_ang_q, rng_step_q;
  logic        [23:0] max_rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q    <= 7'd64;
      map_h_q    <= 7'd64;
      cell_sz_q  <= 16'd256;
      ray_cnt_q  <= 7'd0;
      min_ang_q  <= 16'h8000;
      max_ang_q  <= 16'h7FFF;
      max_rng_q  <= 24'd0;
      rng_step_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MAP_WIDTH:  map_w_q    <= cfg_data_i[6:0];
        CFG_MAP_HEIGHT: map_h_q    <= cfg_data_i[6:0];
        CFG_CELL_SIZE:  cell_sz_q  <= cfg_data_i[15:0];
        CFG_RAY_COUNT:  ray_cnt_q  <= cfg_data_i[6:0];
        CFG_MIN_ANGLE:  min_ang_q  <= cfg_data_i[15:0];
        CFG_MAX_ANGLE:  max_ang_q  <= cfg_data_i[15:0];
        CFG_MAX_RANGE:  max_rng_q  <= cfg_data_i[23:0];
        CFG_RANGE_STEP: rng_step_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Derived: stable over a scan if the user changes config only while idle; not enforced.
  logic [6:0]  side_w, cnt_raw_w, count_w;
  logic [15:0] step_w, span_w;
  logic [13:0] area_w;
  logic        cfg_bad_w;

  always_comb begin
    side_w    = (map_w_q > map_h_q) ? map_w_q : map_h_q;
    step_w    = (rng_step_q != 16'd0) ? rng_step_q : cell_sz_q;
    cnt_raw_w = (ray_cnt_q != 7'd0) ? ray_cnt_q : map_w_q;
    count_w   = (32'(cnt_raw_w) > MAX_RAYS) ? 7'(MAX_RAYS) : cnt_raw_w;
    span_w    = max_ang_q - min_ang_q;
    area_w    = 14'(map_w_q) * 14'(map_h_q);
    cfg_bad_w = (map_w_q == 7'd0) || (map_h_q == 7'd0) || (cell_sz_q == 16'd0) ||
                ($signed(max_ang_q) <= $signed(min_ang_q)) ||
                (32'(area_w) > GRID_CELLS);
  end

  // ---------------------------------------------------------------- datapath regs
  state_e state_q, state_d;

  logic signed [23:0]      px_q, px_d, py_q, py_d;
  logic        [15:0]      head_q, head_d;
  logic        [23:0]      rng_q, rng_d;
  logic        [22:0]      xlim_q, xlim_d, ylim_q, ylim_d;
  logic        [LW-1:0]    limit_q, limit_d, k_q, k_d;
  logic        [6:0]       i_q, i_d;
  logic        [15:0]      off_q, off_d, ang_q, ang_d;
  logic                    phase_q, phase_d, neg_q, neg_d;
  logic signed [16:0]      cos_q, cos_d, sin_q, sin_d;
  logic signed [INC_W-1:0] inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic signed [ACC_W-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic        [DW-1:0]    dist_q, dist_d;
  logic        [6:0]       col_q, col_d, row_q, row_d;

  logic        [5:0]       out_idx_q, out_idx_d;
  logic        [23:0]      out_rng_q, out_rng_d;
  logic                    out_stat_q, out_stat_d, out_last_q, out_last_d;
  logic                    out_valid_q, out_valid_d;

  // Shared multiplier, registered output
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_q;

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Shared divider
  div_req_t         div_req;
  logic             div_busy, div_done;
  logic [QUO_W-1:0] div_quo;

  rcast_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Grid
  logic          grid_we, grid_rdata, grid_busy;
  logic [AW-1:0] grid_raddr;

  rcast_grid #(
    .GRID_CELLS (GRID_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (grid_we),
    .waddr_i (AW'(in_i.cell_index)),
    .wdata_i (in_i.cell_occupied),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata),
    .busy_o  (grid_busy)
  );

  // Current march point: pose plus floor(trig * distance / 2^15)
  logic signed [XW-1:0] x_w, y_w;
  logic        [15:0]   a_w;
  logic        [14:0]   h_w;
  logic        [15:0]   hc_w;
  logic        [16:0]   sq_w;
  logic        [28:0]   p_w;   // h*(32768-h) peaks at 2^28 on a quarter turn

  always_comb begin
    x_w  = XW'(px_q) + XW'($signed(acc_x_q[ACC_W-1:15]));
    y_w  = XW'(py_q) + XW'($signed(acc_y_q[ACC_W-1:15]));
    a_w  = phase_q ? ang_q : (ang_q + ANG_QUARTER);
    h_w  = a_w[14:0];
    hc_w = 16'(ANG_HALF - 17'(h_w));
    sq_w = {1'b0, div_quo[15:0]};
    p_w  = mul_q[28:0];
  end

  logic        emit;
  logic [23:0] emit_val;
  logic        in_acc;

  assign in_i.ready = (state_q == ST_IDLE) && !grid_busy;
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    head_d      = head_q;
    rng_d       = rng_q;
    xlim_d      = xlim_q;
    ylim_d      = ylim_q;
    limit_d     = limit_q;
    k_d         = k_q;
    i_d         = i_q;
    off_d       = off_q;
    ang_d       = ang_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    cos_d       = cos_q;
    sin_d       = sin_q;
    inc_x_d     = inc_x_q;
    inc_y_d     = inc_y_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    dist_d      = dist_q;
    col_d       = col_q;
    row_d       = row_q;
    out_idx_d   = out_idx_q;
    out_rng_d   = out_rng_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    grid_we     = 1'b0;
    grid_raddr  = '0;
    emit        = 1'b0;
    emit_val    = rng_q;

    case (state_q)
      ST_IDLE: begin
        // default range: cell size times larger side (fits 23 bits, never saturates)
        mul_a = $signed({2'b00, cell_sz_q});
        mul_b = $signed({11'b0, side_w});
        if (in_acc) begin
          if (in_i.command == CMD_WRITE) begin
            grid_we = 32'(in_i.cell_index) < GRID_CELLS;
          end else begin
            px_d   = in_i.pose_x;
            py_d   = in_i.pose_y;
            head_d = in_i.pose_heading;
            i_d    = '0;
            if (cfg_bad_w) begin
              out_idx_d   = '0;
              out_rng_d   = '0;
              out_stat_d  = STAT_BAD_CFG;
              out_last_d  = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_OUT;
            end else begin
              state_d = ST_RNG;
            end
          end
        end
      end
      ST_RNG: begin
        rng_d   = (max_rng_q != 24'd0) ? max_rng_q : mul_q[23:0];
        mul_a   = $signed({2'b00, cell_sz_q});
        mul_b   = $signed({11'b0, map_w_q});
        state_d = ST_XL;
      end
      ST_XL: begin
        xlim_d  = mul_q[22:0];
        mul_a   = $signed({2'b00, cell_sz_q});
        mul_b   = $signed({11'b0, map_h_q});
        state_d = ST_YL;
      end
      ST_YL: begin
        ylim_d  = mul_q[22:0];
        state_d = ST_LIM;
      end
      ST_LIM: begin
        // step count = ceil(range / step)
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(rng_q) + DIV_W'(step_w) - DIV_W'(1);
        div_req.den   = DEN_W'(step_w);
        div_req.nbits = NB_LIMIT;
        state_d       = ST_LIMW;
      end
      ST_LIMW: begin
        if (div_done) begin
          limit_d = (32'(div_quo) > MAX_STEPS) ? LW'(MAX_STEPS) : LW'(div_quo);
          state_d = ST_RAY;
        end
      end
      ST_RAY: begin
        mul_a   = $signed({2'b00, span_w});
        mul_b   = $signed({11'b0, i_q});
        state_d = ST_OFF;
      end
      ST_OFF: begin
        if (count_w > 7'd1) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(mul_q[21:0]);
          div_req.den   = DEN_W'(count_w - 7'd1);
          div_req.nbits = NB_ANGLE;
          state_d       = ST_OFFW;
        end else begin
          off_d   = '0;
          state_d = ST_ANG;
        end
      end
      ST_OFFW: begin
        if (div_done) begin
          off_d   = div_quo[15:0];
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        ang_d   = head_q + min_ang_q + off_q;
        phase_d = 1'b0;
        state_d = ST_TRM;
      end
      ST_TRM: begin
        // phase 0 gives the cosine, phase 1 the sine
        neg_d   = a_w[15];
        mul_a   = $signed({3'b000, h_w});
        mul_b   = $signed({2'b00, hc_w});
        state_d = ST_TRD;
      end
      ST_TRD: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({p_w, 19'b0});
        div_req.den   = SIN_DEN_K - DEN_W'({p_w, 2'b00});
        div_req.nbits = NB_ANGLE;
        state_d       = ST_TRW;
      end
      ST_TRW: begin
        if (div_done) begin
          if (!phase_q) begin
            cos_d   = neg_q ? -$signed(sq_w) : $signed(sq_w);
            phase_d = 1'b1;
            state_d = ST_TRM;
          end else begin
            sin_d   = neg_q ? -$signed(sq_w) : $signed(sq_w);
            state_d = ST_INCX;
          end
        end
      end
      ST_INCX: begin
        mul_a   = 18'(cos_q);
        mul_b   = $signed({2'b00, step_w});
        state_d = ST_INCY;
      end
      ST_INCY: begin
        inc_x_d = $signed(mul_q[INC_W-1:0]);
        mul_a   = 18'(sin_q);
        mul_b   = $signed({2'b00, step_w});
        state_d = ST_INIT;
      end
      ST_INIT: begin
        inc_y_d = $signed(mul_q[INC_W-1:0]);
        acc_x_d = '0;
        acc_y_d = '0;
        dist_d  = '0;
        k_d     = '0;
        if (limit_q == '0) begin
          emit = 1'b1;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        acc_x_d = acc_x_q + ACC_W'(inc_x_q);
        acc_y_d = acc_y_q + ACC_W'(inc_y_q);
        dist_d  = dist_q + DW'(step_w);
        k_d     = k_q + LW'(1);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // off the grid: negative, or past width/height times cell size
        if (x_w[XW-1] || y_w[XW-1] || (XW'(xlim_q) <= x_w) || (XW'(ylim_q) <= y_w)) begin
          emit = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(x_w[22:0]);
          div_req.den   = DEN_W'(cell_sz_q);
          div_req.nbits = NB_CELL;
          state_d       = ST_COLW;
        end
      end
      ST_COLW: begin
        if (div_done) begin
          col_d   = div_quo[6:0];
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(y_w[22:0]);
        div_req.den   = DEN_W'(cell_sz_q);
        div_req.nbits = NB_CELL;
        state_d       = ST_ROWW;
      end
      ST_ROWW: begin
        if (div_done) begin
          row_d   = div_quo[6:0];
          state_d = ST_IDX;
        end
      end
      ST_IDX: begin
        mul_a   = $signed({11'b0, row_q});
        mul_b   = $signed({11'b0, map_w_q});
        state_d = ST_RD;
      end
      ST_RD: begin
        grid_raddr = mul_q[AW-1:0] + AW'(col_q);
        state_d    = ST_HIT;
      end
      ST_HIT: begin
        if (grid_rdata) begin
          emit     = 1'b1;
          emit_val = (DW'(rng_q) < dist_q) ? rng_q : 24'(dist_q);
        end else if (k_q == limit_q) begin
          emit = 1'b1;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 7'd1;
            state_d = ST_RAY;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_idx_d   = i_q[5:0];
      out_rng_d   = emit_val;
      out_stat_d  = STAT_OK;
      out_last_d  = (i_q + 7'd1) == count_w;
      out_valid_d = 1'b1;
      state_d     = ST_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      limit_q     <= '0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    head_q     <= head_d;
    rng_q      <= rng_d;
    xlim_q     <= xlim_d;
    ylim_q     <= ylim_d;
    off_q      <= off_d;
    ang_q      <= ang_d;
    neg_q      <= neg_d;
    cos_q      <= cos_d;
    sin_q      <= sin_d;
    inc_x_q    <= inc_x_d;
    inc_y_q    <= inc_y_d;
    acc_x_q    <= acc_x_d;
    acc_y_q    <= acc_y_d;
    dist_q     <= dist_d;
    col_q      <= col_d;
    row_q      <= row_d;
    out_idx_q  <= out_idx_d;
    out_rng_q  <= out_rng_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ray_index   = out_idx_q;
  assign out_o.range_value = out_rng_q;
  assign out_o.status      = out_stat_q;
  assign out_o.last        = out_last_q;

  // ---------------------------------------------------------------- checks
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT) |-> (k_q <= limit_q) && (k_q != '0))
    else $error("march step outside limit");

  a_last_ray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && (out_stat_q == STAT_OK))
      |-> ((7'(out_idx_q) + 7'd1) == count_w))
    else $error("last flag on wrong ray");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_q && !grid_busy)
    else $error("request taken while result pending or grid clearing");

endmodule

`default_nettype wire
